### design/fixed_timestep_accumulator_unit_macros.svh
// Assertion macros shared by the accumulator RTL
`ifndef FIXED_TIMESTEP_ACCUMULATOR_UNIT_MACROS_SVH
`define FIXED_TIMESTEP_ACCUMULATOR_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define FTA_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fta assertion failed");
// next-cycle implication
`define FTA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fta assertion failed");
`else
`define FTA_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define FTA_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

### design/fta_pkg.sv
// Shared types and constants of the fixed-timestep accumulator
`default_nettype none

package fta_pkg;

  localparam int FRAME_W    = 32;
  localparam int BANK_W     = 21;
  localparam int STEP_W     = 20;
  localparam int MAXS_W     = 16;
  localparam int TAKEN_W    = 16;
  localparam int DROP_W     = 21;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam int DEF_MAX_FRAME_US = 250000;
  localparam int DEF_ALPHA_BITS   = 16;

  localparam logic [STEP_W-1:0] RST_FIXED_STEP = 20'd16667;
  localparam logic [MAXS_W-1:0] RST_MAX_STEPS  = 16'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEPS  = 2'd1;

  // command to the shared divider
  typedef struct packed {
    logic start;
    logic frac;   // 1: fraction bits from a remainder, 0: integer quotient
  } div_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

`default_nettype wire

### design/fta_div.sv
// Bit-serial restoring divider shared by the step count and the fraction
`default_nettype none

module fta_div #(
  parameter int ALPHA_BITS = fta_pkg::DEF_ALPHA_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire fta_pkg::div_cmd_t                cmd,
  input  wire logic [fta_pkg::BANK_W-1:0]       dividend,
  input  wire logic [fta_pkg::STEP_W-1:0]       rem_init,
  input  wire logic [fta_pkg::STEP_W-1:0]       divisor,
  output fta_pkg::div_sts_t                     sts,
  output logic [((fta_pkg::BANK_W > ALPHA_BITS) ? fta_pkg::BANK_W : ALPHA_BITS)-1:0] quot,
  output logic [fta_pkg::STEP_W-1:0]            rem
);
  import fta_pkg::*;

  localparam int Q_W   = (BANK_W > ALPHA_BITS) ? BANK_W : ALPHA_BITS;
  localparam int CNT_W = $clog2(Q_W + 1);

  logic [BANK_W-1:0] dvd;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;

  logic [STEP_W:0]   shifted;
  logic [STEP_W+1:0] diff;
  logic              ge;

  // one quotient bit per cycle; rem stays below divisor
  assign shifted = {rem, dvd[BANK_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, divisor};
  assign ge      = ~diff[STEP_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (cmd.start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        done <= 1'b0;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem  <= cmd.frac ? rem_init : '0;
      dvd  <= cmd.frac ? '0 : dividend;
      cnt  <= cmd.frac ? CNT_W'(ALPHA_BITS) : CNT_W'(BANK_W);
      quot <= '0;
    end else if (busy) begin
      rem  <= ge ? diff[STEP_W-1:0] : shifted[STEP_W-1:0];
      dvd  <= {dvd[BANK_W-2:0], 1'b0};
      cnt  <= cnt - CNT_W'(1);
      quot <= {quot[Q_W-2:0], ge};
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;

endmodule

`default_nettype wire

### design/fixed_timestep_accumulator_unit.sv
// Each frame tick banks its clamped frame time (when advance is set), splits the
// bank into whole fixed steps (taken up to max_steps, the rest dropped) and a
// remainder, and reports the remainder over the step as a Q1.ALPHA_BITS
// fraction clamped to 1.0. One tick is handled at a time. A tick with advance
// set runs the integer pass and then the fraction pass, a frozen tick runs the
// fraction pass alone, and a tick under an invalid configuration (zero step or
// zero maximum) or a frozen tick whose bank already holds a whole step runs no
// division. The passes run on a single restoring divider that produces one
// quotient bit per cycle, first for the step count and then
// for the fraction. The finished result sits in an output register, so a stall
// on the result side only holds the block once the next result is ready.
// Configuration writes are always taken and must happen while the block is idle.
`default_nettype none

`include "fixed_timestep_accumulator_unit_macros.svh"

module fixed_timestep_accumulator_unit #(
  parameter int MAX_FRAME_US = fta_pkg::DEF_MAX_FRAME_US,
  parameter int ALPHA_BITS   = fta_pkg::DEF_ALPHA_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [fta_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [fta_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [fta_pkg::FRAME_W-1:0]       frame_time_us,
  input  wire logic                              advance,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [fta_pkg::TAKEN_W-1:0]            steps_taken,
  output logic [fta_pkg::DROP_W-1:0]             steps_dropped,
  output logic                                   invalid,
  output logic [ALPHA_BITS:0]                    alpha_q16
);
  import fta_pkg::*;

  localparam int Q_W = (BANK_W > ALPHA_BITS) ? BANK_W : ALPHA_BITS;
  localparam logic [ALPHA_BITS:0] ALPHA_ONE = {1'b1, {ALPHA_BITS{1'b0}}};

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_INT  = 2'd1;
  localparam logic [1:0] S_FRAC = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]          state;
  logic [STEP_W-1:0]   fixed_step_us;
  logic [MAXS_W-1:0]   max_steps;
  logic [BANK_W-1:0]   time_bank;
  logic [BANK_W-1:0]   whole;
  logic [ALPHA_BITS:0] alpha;
  logic                res_inv;

  logic                in_acc;
  logic                cfg_bad;
  logic                bank_ge_step;
  logic [BANK_W-1:0]   frame_clamp;
  logic [BANK_W-1:0]   bank_sum;
  logic                take_lt;
  logic [TAKEN_W-1:0]  taken_val;
  logic [DROP_W-1:0]   drop_val;
  logic                load_out;

  div_cmd_t            div_cmd;
  div_sts_t            div_sts;
  logic [Q_W-1:0]      div_quot;
  logic [STEP_W-1:0]   div_rem;
  logic [STEP_W-1:0]   div_rem_init;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_acc    = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fixed_step_us <= RST_FIXED_STEP;
      max_steps     <= RST_MAX_STEPS;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FIXED_STEP: fixed_step_us <= cfg_data[STEP_W-1:0];
        CFG_MAX_STEPS:  max_steps     <= cfg_data[MAXS_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_bad      = (fixed_step_us == '0) | (max_steps == '0);
  assign bank_ge_step = (time_bank >= {1'b0, fixed_step_us});
  assign frame_clamp  = (frame_time_us > FRAME_W'(MAX_FRAME_US)) ? BANK_W'(MAX_FRAME_US)
                                                                 : frame_time_us[BANK_W-1:0];
  assign bank_sum     = time_bank + frame_clamp;

  // start the integer pass on an advancing tick with a valid configuration, the
  // fraction pass after it or straight away on a frozen tick with the bank below one step
  always_comb begin
    div_cmd.start = 1'b0;
    div_cmd.frac  = 1'b1;
    if (state == S_IDLE) begin
      if (in_acc && !cfg_bad) begin
        if (advance) begin
          div_cmd.start = 1'b1;
          div_cmd.frac  = 1'b0;
        end else if (!bank_ge_step) begin
          div_cmd.start = 1'b1;
        end
      end
    end else if (state == S_INT) begin
      div_cmd.start = div_sts.done;
    end
  end

  assign div_rem_init = (state == S_INT) ? div_rem : time_bank[STEP_W-1:0];

  fta_div #(
    .ALPHA_BITS (ALPHA_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .cmd      (div_cmd),
    .dividend (bank_sum),
    .rem_init (div_rem_init),
    .divisor  (fixed_step_us),
    .sts      (div_sts),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      time_bank <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (cfg_bad) begin
              state <= S_DONE;
            end else if (advance) begin
              state <= S_INT;
            end else if (bank_ge_step) begin
              state <= S_DONE;
            end else begin
              state <= S_FRAC;
            end
          end
        end
        S_INT: begin
          if (div_sts.done) begin
            time_bank <= {1'b0, div_rem};
            state     <= S_FRAC;
          end
        end
        S_FRAC: begin
          if (div_sts.done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // per-tick working values
  always_ff @(posedge clk) begin
    if (in_acc) begin
      whole   <= '0;
      res_inv <= cfg_bad;
      alpha   <= (cfg_bad || advance || !bank_ge_step) ? '0 : ALPHA_ONE;
    end else begin
      if (state == S_INT && div_sts.done) begin
        whole <= div_quot[BANK_W-1:0];
      end
      if (state == S_FRAC && div_sts.done) begin
        alpha <= {1'b0, div_quot[ALPHA_BITS-1:0]};
      end
    end
  end

  assign take_lt   = (whole < BANK_W'(max_steps));
  assign taken_val = take_lt ? whole[TAKEN_W-1:0] : max_steps;
  assign drop_val  = whole - BANK_W'(taken_val);
  assign load_out  = (state == S_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      steps_taken   <= taken_val;
      steps_dropped <= drop_val;
      invalid       <= res_inv;
      alpha_q16     <= alpha;
    end
  end

  `FTA_ASSERT_NOW(a_idle_div_free, clk, rst, in_ready, !div_sts.busy)
  `FTA_ASSERT_NEXT(a_bank_below_step, clk, rst, (state == S_INT) && div_sts.done, time_bank < {1'b0, fixed_step_us})
  `FTA_ASSERT_NOW(a_invalid_zero, clk, rst, out_valid && invalid, (steps_taken == '0) && (steps_dropped == '0) && (alpha_q16 == '0))
  `FTA_ASSERT_NOW(a_alpha_clamped, clk, rst, out_valid, alpha_q16 <= ALPHA_ONE)

endmodule

`default_nettype wire
